/* rtl/core/bpu_pkg.sv */
// bpu_pkg: shared types, format and job codes for the BMP pixel unpacker.
// Used by bpu_front, bpu_queue, bpu_back and bmp_pixel_unpacker_top.
`default_nettype none
package bpu_pkg;

  localparam int unsigned MaxWidth     = 8192;
  localparam int unsigned HeightLimit  = 8192;
  localparam int unsigned PaletteDepth = 256;

  localparam logic [2:0] FMT_1BPP  = 3'd0;
  localparam logic [2:0] FMT_4BPP  = 3'd1;
  localparam logic [2:0] FMT_8BPP  = 3'd2;
  localparam logic [2:0] FMT_16    = 3'd3;
  localparam logic [2:0] FMT_16M   = 3'd4;
  localparam logic [2:0] FMT_24    = 3'd5;
  localparam logic [2:0] FMT_32    = 3'd6;
  localparam logic [2:0] FMT_32M   = 3'd7;

  localparam logic [1:0] KIND_PAL    = 2'd0;
  localparam logic [1:0] KIND_INDEX  = 2'd1;
  localparam logic [1:0] KIND_DIRECT = 2'd2;

  localparam logic [2:0] REG_FORMAT = 3'd0;
  localparam logic [2:0] REG_WIDTH  = 3'd1;
  localparam logic [2:0] REG_HEIGHT = 3'd2;
  localparam logic [2:0] REG_TOPDN  = 3'd3;
  localparam logic [2:0] REG_RMASK  = 3'd4;
  localparam logic [2:0] REG_GMASK  = 3'd5;
  localparam logic [2:0] REG_BMASK  = 3'd6;
  localparam logic [2:0] REG_AMASK  = 3'd7;

  localparam logic [7:0] SCALE5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  typedef struct packed {
    logic [2:0]  fmt;
    logic [13:0] width;
    logic [13:0] height;
    logic        first_row_top;
    logic [31:0] red_mask;
    logic [31:0] green_mask;
    logic [31:0] blue_mask;
    logic [31:0] alpha_mask;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  fmt;
    logic [31:0] data;
    logic [13:0] col;
    logic [12:0] row;
    logic [3:0]  cnt;
    logic [7:0]  pal_idx;
    logic [23:0] pal_rgb;
  } job_t;

endpackage
`default_nettype wire

/* rtl/core/bmp_pixel_unpacker_top.sv */
// bmp_pixel_unpacker_top: register file and wiring of front, queue and back.
// Depends on bpu_pkg, bpu_front, bpu_queue and bpu_back.
//
//   channel | handshake              | beat
//   in      | in_valid_i/in_stall_o  | palette write or one pixel-array byte
//   out     | out_valid_o/out_stall_i| one ARGB8888 pixel with position
//   cfg     | psel/penable/pready    | 32-bit register write or read
//
// The front takes a beat per cycle while the two-entry queue has room.
// The back runs one job at a time: a palette write completes on pop, an
// indexed beat does a palette RAM read and an emit per pixel, an unmasked
// pixel is emitted, a masked pixel runs 4 channels via one 8-step divider.
// A stalled result beat holds the back; a full queue raises in_stall_o.
// Reset clears counters and queue; the palette holds garbage until written.
`default_nettype none
module bmp_pixel_unpacker_top #(
  parameter int unsigned PALETTE_DEPTH = bpu_pkg::PaletteDepth
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire         cmd_i,
  input  wire  [7:0]  palette_index_i,
  input  wire  [7:0]  entry_blue_i,
  input  wire  [7:0]  entry_green_i,
  input  wire  [7:0]  entry_red_i,
  input  wire  [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [7:0]  alpha_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [12:0] column_o,
  output logic [12:0] dest_row_o,
  output logic        last_of_run_o,
  output logic        image_done_o
);
  import bpu_pkg::*;

  logic [2:0]  fmt_q;
  logic [13:0] width_q, height_q;
  logic        topdn_q;
  logic [31:0] rmask_q, gmask_q, bmask_q, amask_q;

  logic        wr_en;
  cfg_t        cfg;
  job_t        push_job, head;
  logic        push, full, pop, empty;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q    <= FMT_32;
      width_q  <= 14'd1;
      height_q <= 14'd1;
      topdn_q  <= 1'b0;
      rmask_q  <= 32'h00FF_0000;
      gmask_q  <= 32'h0000_FF00;
      bmask_q  <= 32'h0000_00FF;
      amask_q  <= 32'd0;
    end else if (wr_en) begin
      case (paddr[4:2])
        REG_FORMAT: fmt_q    <= pwdata[2:0];
        REG_WIDTH:  width_q  <= pwdata[13:0];
        REG_HEIGHT: height_q <= pwdata[13:0];
        REG_TOPDN:  topdn_q  <= pwdata[0];
        REG_RMASK:  rmask_q  <= pwdata;
        REG_GMASK:  gmask_q  <= pwdata;
        REG_BMASK:  bmask_q  <= pwdata;
        REG_AMASK:  amask_q  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FORMAT: prdata = {29'd0, fmt_q};
      REG_WIDTH:  prdata = {18'd0, width_q};
      REG_HEIGHT: prdata = {18'd0, height_q};
      REG_TOPDN:  prdata = {31'd0, topdn_q};
      REG_RMASK:  prdata = rmask_q;
      REG_GMASK:  prdata = gmask_q;
      REG_BMASK:  prdata = bmask_q;
      default:    prdata = amask_q;
    endcase
  end

  always_comb begin
    cfg.fmt           = fmt_q;
    cfg.width         = (width_q == 14'd0) ? 14'd1 :
                        ((32'(width_q) > MaxWidth) ? 14'(MaxWidth) : width_q);
    cfg.height        = (height_q == 14'd0) ? 14'd1 :
                        ((32'(height_q) > HeightLimit) ? 14'(HeightLimit) : height_q);
    cfg.first_row_top = topdn_q;
    cfg.red_mask      = rmask_q;
    cfg.green_mask    = gmask_q;
    cfg.blue_mask     = bmask_q;
    cfg.alpha_mask    = amask_q;
  end

  bpu_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .cmd_i           (cmd_i),
    .palette_index_i (palette_index_i),
    .entry_blue_i    (entry_blue_i),
    .entry_green_i   (entry_green_i),
    .entry_red_i     (entry_red_i),
    .data_byte_i     (data_byte_i),
    .push_job_o      (push_job),
    .push_o          (push),
    .full_i          (full)
  );

  bpu_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .full_o     (full),
    .pop_i      (pop),
    .head_o     (head),
    .empty_o    (empty)
  );

  bpu_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .head_i        (head),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .alpha_o       (alpha_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .column_o      (column_o),
    .dest_row_o    (dest_row_o),
    .last_of_run_o (last_of_run_o),
    .image_done_o  (image_done_o)
  );

endmodule
`default_nettype wire

/* rtl/core/bpu_front.sv */
// bpu_front: accepts input beats, gathers bytes per pixel, tracks row padding
// and counters, and issues one job per beat that yields work. Uses bpu_pkg.
`default_nettype none
module bpu_front (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bpu_pkg::cfg_t      cfg_i,
  input  wire                in_valid_i,
  output logic               in_stall_o,
  input  wire                cmd_i,
  input  wire  [7:0]         palette_index_i,
  input  wire  [7:0]         entry_blue_i,
  input  wire  [7:0]         entry_green_i,
  input  wire  [7:0]         entry_red_i,
  input  wire  [7:0]         data_byte_i,
  output bpu_pkg::job_t      push_job_o,
  output logic               push_o,
  input  wire                full_i
);
  import bpu_pkg::*;

  logic [23:0] gather_q, gather_d;
  logic [1:0]  bip_q, bip_d;
  logic [14:0] bir_q, bir_d;
  logic [13:0] col_q, col_d;
  logic [12:0] row_q, row_d;

  logic        accept;
  logic [18:0] wbits;
  logic [16:0] row_len;
  logic [12:0] row_eff;
  logic        col_lt;
  logic [13:0] col_rem;
  logic [3:0]  n;
  logic [1:0]  needm1;
  logic [31:0] v;
  logic        direct;
  logic [14:0] bir_inc;
  logic        row_end;
  logic [13:0] row_inc;

  assign accept     = in_valid_i & ~full_i;
  assign in_stall_o = full_i;

  always_comb begin
    case (cfg_i.fmt)
      FMT_1BPP: wbits = {5'd0, cfg_i.width};
      FMT_4BPP: wbits = {3'd0, cfg_i.width, 2'd0};
      FMT_8BPP: wbits = {2'd0, cfg_i.width, 3'd0};
      FMT_16, FMT_16M: wbits = {1'b0, cfg_i.width, 4'd0};
      FMT_24: wbits = {1'b0, cfg_i.width, 4'd0} + {2'd0, cfg_i.width, 3'd0};
      default: wbits = {cfg_i.width, 5'd0};
    endcase
    case (cfg_i.fmt)
      FMT_16, FMT_16M: needm1 = 2'd1;
      FMT_24: needm1 = 2'd2;
      default: needm1 = 2'd3;
    endcase
  end

  always_comb begin
    logic [19:0] wsum;
    wsum    = {1'b0, wbits} + 20'd31;
    row_len = {wsum[19:5], 2'b00};
  end

  assign row_eff = ({1'b0, row_q} >= cfg_i.height) ? 13'd0 : row_q;
  assign col_lt  = col_q < cfg_i.width;
  assign col_rem = cfg_i.width - col_q;
  assign bir_inc = bir_q + 15'd1;
  assign row_end = ({2'b00, bir_inc} >= row_len) || (bir_inc == 15'd0);
  assign row_inc = {1'b0, row_eff} + 14'd1;

  always_comb begin
    n        = 4'd0;
    v        = 32'd0;
    direct   = 1'b0;
    gather_d = gather_q;
    bip_d    = bip_q;
    if (col_lt) begin
      case (cfg_i.fmt)
        FMT_1BPP: n = (col_rem >= 14'd8) ? 4'd8 : col_rem[3:0];
        FMT_4BPP: n = (col_rem >= 14'd2) ? 4'd2 : 4'd1;
        FMT_8BPP: n = 4'd1;
        default: begin
          direct = 1'b1;
          if (({1'b0, bip_q} + 3'd1) < ({1'b0, needm1} + 3'd1)) begin
            gather_d = gather_q | ({16'd0, data_byte_i} << {bip_q, 3'b000});
            bip_d    = bip_q + 2'd1;
          end else begin
            v        = {8'd0, gather_q} | ({24'd0, data_byte_i} << {needm1, 3'b000});
            n        = 4'd1;
            gather_d = 24'd0;
            bip_d    = 2'd0;
          end
        end
      endcase
    end
    col_d = col_q + {10'd0, n};
    bir_d = bir_inc;
    row_d = row_eff;
    if (row_end) begin
      bir_d    = 15'd0;
      col_d    = 14'd0;
      bip_d    = 2'd0;
      gather_d = 24'd0;
      row_d    = (row_inc >= cfg_i.height) ? 13'd0 : row_inc[12:0];
    end
  end

  always_comb begin
    push_job_o.kind    = cmd_i ? (direct ? KIND_DIRECT : KIND_INDEX) : KIND_PAL;
    push_job_o.fmt     = cfg_i.fmt;
    push_job_o.data    = direct ? v : {24'd0, data_byte_i};
    push_job_o.col     = col_q;
    push_job_o.row     = row_eff;
    push_job_o.cnt     = n;
    push_job_o.pal_idx = palette_index_i;
    push_job_o.pal_rgb = {entry_red_i, entry_green_i, entry_blue_i};
    push_o             = accept && (!cmd_i || (n != 4'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_q <= 24'd0;
      bip_q    <= 2'd0;
      bir_q    <= 15'd0;
      col_q    <= 14'd0;
      row_q    <= 13'd0;
    end else if (accept && cmd_i) begin
      gather_q <= gather_d;
      bip_q    <= bip_d;
      bir_q    <= bir_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/core/bpu_queue.sv */
// bpu_queue: two-entry job queue between front and back.
// Uses bpu_pkg::job_t.
`default_nettype none
module bpu_queue (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  bpu_pkg::job_t      push_job_i,
  output logic               full_o,
  input  wire                pop_i,
  output bpu_pkg::job_t      head_o,
  output logic               empty_o
);
  import bpu_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job queue underflow");
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("job queue count out of range");
`endif

endmodule
`default_nettype wire

/* rtl/core/bpu_back.sv */
// bpu_back: runs jobs: palette writes and reads, channel scaling with a
// shared bit-serial divider, and the registered result beat. Uses bpu_pkg.
`default_nettype none
module bpu_back #(
  parameter int unsigned PALETTE_DEPTH = bpu_pkg::PaletteDepth
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  bpu_pkg::cfg_t      cfg_i,
  input  bpu_pkg::job_t      head_i,
  input  wire                empty_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_stall_i,
  output logic [7:0]         alpha_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [12:0]        column_o,
  output logic [12:0]        dest_row_o,
  output logic               last_of_run_o,
  output logic               image_done_o
);
  import bpu_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRD   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [23:0] pal_mem [PALETTE_DEPTH];
  logic [23:0] rd_q;
  logic        inr_q;

  logic [2:0]  state_q, state_d;
  job_t        job_q;
  logic [2:0]  k_q;
  logic [13:0] col_q;
  logic [1:0]  c_q;
  logic [2:0]  s_q;
  logic [39:0] r_q, dv_q;
  logic [7:0]  qt_q;
  logic [7:0]  ch_q [4];

  logic        out_valid_q;
  logic [7:0]  a_q, r8_q, g_q, b_q;
  logic [12:0] col_out_q, drow_q;
  logic        last_q, done_q;

  logic [7:0]  idx;
  logic [31:0] vm, mask_sel, x;
  logic [39:0] n0;
  logic        ge;
  logic [7:0]  qn;
  logic        out_free, out_load, last_px;
  logic [7:0]  pa, pr, pg, pb;
  logic [13:0] drow_w;

  always_comb begin
    case (job_q.fmt)
      FMT_1BPP: idx = {7'd0, job_q.data[3'd7 - k_q]};
      FMT_4BPP: idx = (k_q == 3'd0) ? {4'd0, job_q.data[7:4]} : {4'd0, job_q.data[3:0]};
      default:  idx = job_q.data[7:0];
    endcase
    case (c_q)
      2'd0:    mask_sel = cfg_i.alpha_mask;
      2'd1:    mask_sel = cfg_i.red_mask;
      2'd2:    mask_sel = cfg_i.green_mask;
      default: mask_sel = cfg_i.blue_mask;
    endcase
  end

  assign vm = (job_q.fmt == FMT_16M) ? {16'd0, job_q.data[15:0]} : job_q.data;
  assign x  = vm & mask_sel;
  assign n0 = {x, 8'd0} - {8'd0, x};
  assign ge = r_q >= dv_q;
  assign qn = {qt_q[6:0], ge};

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = (state_q == S_EMIT) && out_free;
  assign last_px  = (job_q.kind != KIND_INDEX) || (({1'b0, k_q} + 4'd1) == job_q.cnt);
  assign pop_o    = (state_q == S_IDLE) && !empty_i;

  always_comb begin
    pa = 8'hFF;
    pr = 8'd0;
    pg = 8'd0;
    pb = 8'd0;
    if (job_q.kind == KIND_INDEX) begin
      if (inr_q) {pr, pg, pb} = rd_q;
    end else begin
      case (job_q.fmt)
        FMT_16: begin
          pr = SCALE5[job_q.data[14:10]];
          pg = SCALE5[job_q.data[9:5]];
          pb = SCALE5[job_q.data[4:0]];
        end
        FMT_24: {pr, pg, pb} = job_q.data[23:0];
        FMT_32: begin
          {pr, pg, pb} = job_q.data[23:0];
          if (job_q.data[31:24] != 8'd0) pa = job_q.data[31:24];
        end
        default: begin
          pr = ch_q[1];
          pg = ch_q[2];
          pb = ch_q[3];
          if ((job_q.fmt == FMT_32M) && (cfg_i.alpha_mask != 32'd0)) pa = ch_q[0];
        end
      endcase
    end
  end

  assign drow_w = cfg_i.height - 14'd1 - {1'b0, job_q.row};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            KIND_PAL:   state_d = S_IDLE;
            KIND_INDEX: state_d = S_PRD;
            default: begin
              if ((head_i.fmt == FMT_16M) || (head_i.fmt == FMT_32M)) state_d = S_DINIT;
              else state_d = S_EMIT;
            end
          endcase
        end
      end
      S_PRD:   state_d = S_EMIT;
      S_DINIT: state_d = S_DIV;
      S_DIV: begin
        if (s_q == 3'd7) state_d = (c_q == 2'd3) ? S_EMIT : S_DINIT;
      end
      S_EMIT: begin
        if (out_free) state_d = last_px ? S_IDLE : S_PRD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (head_i.kind == KIND_PAL) && (32'(head_i.pal_idx) < PALETTE_DEPTH)) begin
      pal_mem[head_i.pal_idx[AW-1:0]] <= head_i.pal_rgb;
    end
    if (state_q == S_PRD) begin
      rd_q  <= pal_mem[idx[AW-1:0]];
      inr_q <= 32'(idx) < PALETTE_DEPTH;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) job_q <= head_i;
    case (state_q)
      S_DINIT: begin
        r_q  <= n0;
        dv_q <= {1'b0, mask_sel, 7'd0};
        qt_q <= 8'd0;
      end
      S_DIV: begin
        if (ge) r_q <= r_q - dv_q;
        dv_q <= dv_q >> 1;
        qt_q <= qn;
        if (s_q == 3'd7) ch_q[c_q] <= (mask_sel == 32'd0) ? 8'd0 : qn;
      end
      default: ;
    endcase
    if (out_load) begin
      a_q       <= pa;
      r8_q      <= pr;
      g_q       <= pg;
      b_q       <= pb;
      col_out_q <= col_q[12:0];
      drow_q    <= cfg_i.first_row_top ? job_q.row : drow_w[12:0];
      last_q    <= last_px;
      done_q    <= (col_q == (cfg_i.width - 14'd1)) &&
                   ({1'b0, job_q.row} == (cfg_i.height - 14'd1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      k_q         <= 3'd0;
      col_q       <= 14'd0;
      c_q         <= 2'd0;
      s_q         <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        k_q   <= 3'd0;
        col_q <= head_i.col;
        c_q   <= 2'd0;
      end
      if (state_q == S_DINIT) s_q <= 3'd0;
      if (state_q == S_DIV) begin
        s_q <= s_q + 3'd1;
        if (s_q == 3'd7) c_q <= c_q + 2'd1;
      end
      if (out_load) begin
        k_q   <= k_q + 3'd1;
        col_q <= col_q + 14'd1;
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign alpha_o       = a_q;
  assign red_o         = r8_q;
  assign green_o       = g_q;
  assign blue_o        = b_q;
  assign column_o      = col_out_q;
  assign dest_row_o    = drow_q;
  assign last_of_run_o = last_q;
  assign image_done_o  = done_q;

`ifndef SYNTHESIS
  a_read_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PRD) |=> (state_q == S_EMIT))
    else $error("palette read not followed by emit");
  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EMIT) && (job_q.kind == KIND_INDEX)) |-> ({1'b0, k_q} < job_q.cnt))
    else $error("indexed run overran its pixel count");
  a_beat_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q != S_EMIT) && out_valid_q && !out_stall_i) |=> !out_valid_q)
    else $error("result beat repeated");
`endif

endmodule
`default_nettype wire
